// ===== hw/rtl/krdt_pkg.sv =====
// ----------------------------------------------------------------------------
// krdt_pkg
// Shared types and constants for the key repeat / double-tap qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package krdt_pkg;

  // Default key mask width
  localparam int KEY_BITS_DEFAULT = 16;

  // Field widths
  localparam int KEY_W  = 16;
  localparam int CNT_W  = 16;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 3;

  // Event codes
  localparam logic [MODE_W-1:0] MODE_DOWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DPAD_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDIT_KEY     = 3'd4;

  // Register reset values
  localparam logic [CNT_W-1:0] RST_REPEAT_DELAY = 16'd20;
  localparam logic [CNT_W-1:0] RST_REPEAT_RATE  = 16'd4;
  localparam logic [CNT_W-1:0] RST_TAP_WINDOW   = 16'd15;
  localparam logic [KEY_W-1:0] RST_DPAD_MASK    = 16'd15;
  localparam logic [KEY_W-1:0] RST_EDIT_KEY     = 16'd16;

  // Input word
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key_bits;
  } krdt_in_t;

  // Output word
  typedef struct packed {
    logic [KEY_W-1:0] held_mask;
    logic             double_tap;
  } krdt_out_t;

  // Configuration register set
  typedef struct packed {
    logic [CNT_W-1:0] repeat_delay;
    logic [CNT_W-1:0] repeat_rate;
    logic [CNT_W-1:0] double_tap_window;
    logic [KEY_W-1:0] dpad_mask;
    logic [KEY_W-1:0] edit_key;
  } krdt_cfg_t;

  // Core result: word plus its emit flag
  typedef struct packed {
    logic      emit;
    krdt_out_t data;
  } krdt_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/krdt_cfg.sv =====
// ----------------------------------------------------------------------------
// krdt_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module krdt_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [krdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [krdt_pkg::KEY_W-1:0]     cfg_data,
  output krdt_pkg::krdt_cfg_t                 cfg
);

  krdt_pkg::krdt_cfg_t regs;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.repeat_delay      <= krdt_pkg::RST_REPEAT_DELAY;
      regs.repeat_rate       <= krdt_pkg::RST_REPEAT_RATE;
      regs.double_tap_window <= krdt_pkg::RST_TAP_WINDOW;
      regs.dpad_mask         <= krdt_pkg::RST_DPAD_MASK;
      regs.edit_key          <= krdt_pkg::RST_EDIT_KEY;
    end else if (cfg_write) begin
      unique case (cfg_index)
        krdt_pkg::CFG_REPEAT_DELAY: regs.repeat_delay      <= cfg_data;
        krdt_pkg::CFG_REPEAT_RATE:  regs.repeat_rate       <= cfg_data;
        krdt_pkg::CFG_TAP_WINDOW:   regs.double_tap_window <= cfg_data;
        krdt_pkg::CFG_DPAD_MASK:    regs.dpad_mask         <= cfg_data;
        krdt_pkg::CFG_EDIT_KEY:     regs.edit_key          <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== hw/rtl/krdt_core.sv =====
// ----------------------------------------------------------------------------
// krdt_core
// Held-key, double-tap and repeat state with the per-event update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module krdt_core #(
  parameter int KEY_BITS = krdt_pkg::KEY_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire krdt_pkg::krdt_in_t  ev,
  input  wire krdt_pkg::krdt_cfg_t cfg,
  output krdt_pkg::krdt_res_t      res
);

  // Only key bits below both the key width and the field width can be held
  localparam int HW = (KEY_BITS < krdt_pkg::KEY_W) ? KEY_BITS : krdt_pkg::KEY_W;

  logic [HW-1:0]              held;
  logic [HW-1:0]              held_next;
  logic [krdt_pkg::CNT_W-1:0] tap_cnt;
  logic [krdt_pkg::CNT_W-1:0] tap_cnt_next;
  logic [krdt_pkg::CNT_W-1:0] rep_cnt;
  logic [krdt_pkg::CNT_W-1:0] rep_cnt_next;

  logic [HW-1:0]              keys;
  logic [HW-1:0]              dpad;
  logic [HW-1:0]              held_or;
  logic [HW-1:0]              held_dpad;
  logic [krdt_pkg::KEY_W-1:0] keys_full;
  logic [krdt_pkg::CNT_W-1:0] rep_dec;
  logic                       is_edit;
  logic                       single;

  // Operand prep
  always_comb begin
    keys      = ev.key_bits[HW-1:0];
    dpad      = cfg.dpad_mask[HW-1:0];
    keys_full = krdt_pkg::KEY_W'(keys);
    is_edit   = (keys_full == cfg.edit_key);
    held_or   = held | keys;
    held_dpad = held & dpad;
    // exactly one held d-pad key
    single    = (held_dpad != '0) && ((held_dpad & (held_dpad - 1'b1)) == '0);
    rep_dec   = rep_cnt - 1'b1;
  end

  // Event update
  always_comb begin
    held_next    = held;
    tap_cnt_next = tap_cnt;
    rep_cnt_next = rep_cnt;
    res.emit     = 1'b0;
    res.data     = '0;
    unique case (ev.mode)
      krdt_pkg::MODE_DOWN: begin
        held_next = held_or;
        if ((keys & dpad) != '0) begin
          // new direction replaces any other held direction
          held_next    = (held_or & ~dpad) | keys;
          rep_cnt_next = cfg.repeat_delay;
        end
        tap_cnt_next        = '0;
        res.emit            = 1'b1;
        res.data.held_mask  = krdt_pkg::KEY_W'(held_next);
        res.data.double_tap = is_edit && (tap_cnt != '0);
      end
      krdt_pkg::MODE_UP: begin
        held_next = held & ~keys;
        if (is_edit) begin
          tap_cnt_next = cfg.double_tap_window;
        end
        res.emit = (held_next == '0);
      end
      krdt_pkg::MODE_TICK: begin
        if (tap_cnt != '0) begin
          tap_cnt_next = tap_cnt - 1'b1;
        end
        if (rep_cnt != '0) begin
          if (single) begin
            if (rep_dec == '0) begin
              // repeat fires, reload with the rate
              rep_cnt_next       = cfg.repeat_rate;
              res.emit           = 1'b1;
              res.data.held_mask = krdt_pkg::KEY_W'(held);
            end else begin
              rep_cnt_next = rep_dec;
            end
          end else begin
            rep_cnt_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      tap_cnt <= '0;
      rep_cnt <= '0;
    end else if (fire) begin
      held    <= held_next;
      tap_cnt <= tap_cnt_next;
      rep_cnt <= rep_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/key_repeat_double_tap_qualifier.sv =====
// ----------------------------------------------------------------------------
// key_repeat_double_tap_qualifier
// Keypad qualifier: held-button mask, edit-key double tap and d-pad repeat.
// ----------------------------------------------------------------------------
// Order: an accepted event waits in the input register until the result slot
//   is free or draining; its emitted result then loads into the result register.
// Throughput: one event per cycle (single-pass update) unless the output stalls.
// Reset (synchronous): held mask and both counters clear, registers take
//   their default values, both pipeline registers empty.
`default_nettype none

module key_repeat_double_tap_qualifier #(
  parameter int KEY_BITS = krdt_pkg::KEY_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire krdt_pkg::krdt_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output krdt_pkg::krdt_out_t                 out_data,
  input  wire logic                           cfg_write,
  input  wire logic [krdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [krdt_pkg::KEY_W-1:0]     cfg_data
);

  krdt_pkg::krdt_cfg_t cfg;
  krdt_pkg::krdt_in_t  s_data;
  krdt_pkg::krdt_res_t res;
  logic                s_valid;
  logic                s_fire;

  // Configuration registers
  krdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Event stage retires when the result slot is free or being drained
  assign s_fire   = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || s_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_data <= in_data;
    end
  end

  // State and update logic
  krdt_core #(
    .KEY_BITS (KEY_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (s_fire),
    .ev   (s_data),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && res.emit) begin
      out_data <= res.data;
    end
  end

  // Checks
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_fire |=> s_valid && $stable(s_data))
    else $error("event stage lost or changed a stalled word");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    s_fire && res.emit |=> out_valid && (out_data == $past(res.data)))
    else $error("emitted result not captured");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s_valid |-> in_ready)
    else $error("empty stage not ready");

endmodule

`default_nettype wire
